// ----- hw/rtl/efla_pkg.sv -----
// ============================================================================
// efla_pkg: shared types and constants of the free list allocator
// Heap geometry, status codes, datapath operations, status bundle and
// the power-up layout of the heap memory.
// ============================================================================
package efla_pkg;

    // heap geometry
    localparam int HEAP_BYTES  = 65536;
    localparam int HEAP_WORDS  = HEAP_BYTES / 4;
    localparam int WORD_AW     = $clog2(HEAP_WORDS);
    localparam int WALK_LIMIT  = HEAP_BYTES / 8;
    localparam int WALK_W      = $clog2(WALK_LIMIT) + 1;
    localparam int BRK_W       = $clog2(HEAP_BYTES) + 1;
    localparam int ALIGN_BYTES = 8;
    localparam int RESET_CHUNK = 1 << 12;
    localparam int MIN_BLOCK   = 16;

    // field widths
    localparam int EXT_W   = 17;
    localparam int NEED_W  = 17;
    localparam int CHUNK_W = 18;
    localparam int REQ_W   = 16;
    localparam int ADDR_W  = 16;

    localparam logic [31:0] SIZE_MASK = ~32'h0000_0007;
    localparam logic [31:0] ALLOC_BIT = 32'h0000_0001;
    localparam logic [31:0] FIRST_BP  = 32'd16;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NULL     = 2'd2
    } status_code_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_code_t;

    // datapath operations, one per controller step
    typedef enum logic [5:0] {
        OP_NONE, OP_CLEAR, OP_LOAD,
        OP_RD_HDR, OP_RD_PB_HDR, OP_RD_NB_HDR,
        OP_FF_RD_NX, OP_FF_NX, OP_FAIL, OP_GROW,
        OP_GW1, OP_GW2, OP_GW3, OP_GW4, OP_GW5,
        OP_MG1, OP_MG2, OP_MG3, OP_MG4, OP_MG5,
        OP_MA2, OP_MA3, OP_MA4,
        OP_MB2, OP_MB4,
        OP_MC0, OP_MC2, OP_MC3, OP_MC5,
        OP_MINS, OP_LI1, OP_LI2,
        OP_LR1, OP_LR2, OP_LR3, OP_LR4, OP_LR5, OP_LR6, OP_LR7,
        OP_TK1, OP_TK2, OP_TK3, OP_TK4,
        OP_TK5, OP_TK6, OP_TK7, OP_TK8, OP_TK9, OP_TK10,
        OP_FR2, OP_FR4, OP_FR5, OP_FR6,
        OP_DONE
    } dp_op_t;

    // flags from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic in_free;
        logic in_null;
        logic walk_done;
        logic fit;
        logic grow_fail;
        logic bp_zero;
        logic x_zero;
        logic fh_zero;
        logic prv_zero;
        logic nxt_zero;
        logic rd_alloc;
        logic p_alloc;
        logic split_ok;
    } dp_status_t;

    // power-up heap contents: prologue, first free chunk, epilogue
    function automatic logic [31:0] init_word(input logic [WORD_AW-1:0] idx);
        logic [31:0] w;
        w = 32'd0;
        if (idx == WORD_AW'(1) || idx == WORD_AW'(2)) begin
            w = 32'd8 | ALLOC_BIT;
        end
        else if (idx == WORD_AW'(3)) begin
            w = 32'(RESET_CHUNK);
        end
        else if (idx == WORD_AW'((16 + RESET_CHUNK - 8) / 4)) begin
            w = 32'(RESET_CHUNK);
        end
        else if (idx == WORD_AW'((16 + RESET_CHUNK - 4) / 4)) begin
            w = ALLOC_BIT;
        end
        return w;
    endfunction

endpackage

// ----- hw/rtl/efla_datapath.sv -----
// ============================================================================
// efla_datapath: heap memory, pointer registers and output register
// Performs at most one memory access per operation code from the controller and
// reports the flags that steer the sequence.
// ============================================================================
module efla_datapath
    import efla_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_op_t               op,
    output dp_status_t           stat,
    input  logic                 cfg_we,
    input  logic [EXT_W-1:0]     cfg_wdata,
    input  logic                 command,
    input  logic [REQ_W-1:0]     request_size,
    input  logic [ADDR_W-1:0]    block_address,
    output logic [ADDR_W-1:0]    result_address,
    output logic [1:0]           status
);

    logic [31:0] heap_mem [HEAP_WORDS];
    logic [31:0] rd_q_reg;
    logic        rd_oob_reg;
    logic [31:0] rdv;
    logic [31:0] rsz;

    logic [WORD_AW-1:0] clr_reg, clr_next;
    logic [31:0]        fh_reg, fh_next;
    logic [BRK_W-1:0]   brk_reg, brk_next;
    logic [EXT_W-1:0]   ext_reg;

    logic [31:0] bp_reg, bp_next, pb_reg, pb_next, nb_reg, nb_next;
    logic [31:0] sz_reg, sz_next, tot_reg, tot_next, x_reg, x_next;
    logic [31:0] prv_reg, prv_next, nxt_reg, nxt_next, fs_reg, fs_next;
    logic [NEED_W-1:0]  need_reg, need_next;
    logic [CHUNK_W-1:0] bytes_reg, bytes_next;
    logic [WALK_W-1:0]  walk_reg, walk_next;
    logic               palloc_reg, palloc_next;
    logic [ADDR_W-1:0]  res_reg, res_next;
    logic [1:0]         st_reg, st_next;
    logic [ADDR_W-1:0]  oaddr_reg, oaddr_next;
    logic [1:0]         ost_reg, ost_next;

    logic [CHUNK_W-1:0] chunk;
    logic [CHUNK_W-1:0] grow_bytes;
    logic [NEED_W-1:0]  in_need;
    logic [31:0]        need32, rem;

    logic               acc_re, acc_we, in_range;
    logic [31:0]        acc_addr, acc_wdata;
    logic               mem_wr;
    logic [WORD_AW-1:0] mem_idx;

    // read data, zero outside the heap
    assign rdv = rd_oob_reg ? 32'd0 : rd_q_reg;
    assign rsz = rdv & SIZE_MASK;

    // block size arithmetic
    assign chunk = (CHUNK_W'(ext_reg) + CHUNK_W'(ALIGN_BYTES - 1))
                   & ~CHUNK_W'(ALIGN_BYTES - 1);
    assign grow_bytes = (CHUNK_W'(need_reg) > chunk) ? CHUNK_W'(need_reg) : chunk;
    assign in_need = (request_size < REQ_W'(ALIGN_BYTES)) ? NEED_W'(MIN_BLOCK)
                   : ((NEED_W'(request_size) + NEED_W'(2 * ALIGN_BYTES - 1))
                      & ~NEED_W'(ALIGN_BYTES - 1));
    assign need32 = 32'(need_reg);
    assign rem    = fs_reg - need32;

    // flags
    always_comb
    begin
        stat.clear_done = (clr_reg == WORD_AW'(HEAP_WORDS - 1));
        stat.in_free    = (command == CMD_FREE);
        stat.in_null    = (command == CMD_FREE) ? (block_address == '0)
                                                : (request_size == '0);
        stat.walk_done  = (bp_reg == 32'd0) || (walk_reg == WALK_W'(WALK_LIMIT));
        stat.fit        = (rsz >= need32);
        stat.grow_fail  = (32'(grow_bytes) > (32'(HEAP_BYTES) - 32'(brk_reg)));
        stat.bp_zero    = (bp_reg == 32'd0);
        stat.x_zero     = (x_reg == 32'd0);
        stat.fh_zero    = (fh_reg == 32'd0);
        stat.prv_zero   = (prv_reg == 32'd0);
        stat.nxt_zero   = (nxt_reg == 32'd0);
        stat.rd_alloc   = rdv[0];
        stat.p_alloc    = palloc_reg;
        stat.split_ok   = (fs_reg >= need32) && (rem >= 32'(MIN_BLOCK));
    end

    // operation decode
    always_comb
    begin
        clr_next = clr_reg;   fh_next = fh_reg;     brk_next = brk_reg;
        bp_next = bp_reg;     pb_next = pb_reg;     nb_next = nb_reg;
        sz_next = sz_reg;     tot_next = tot_reg;   x_next = x_reg;
        prv_next = prv_reg;   nxt_next = nxt_reg;   fs_next = fs_reg;
        need_next = need_reg; bytes_next = bytes_reg; walk_next = walk_reg;
        palloc_next = palloc_reg; res_next = res_reg; st_next = st_reg;
        oaddr_next = oaddr_reg;   ost_next = ost_reg;
        acc_re = 1'b0; acc_we = 1'b0; acc_addr = 32'd0; acc_wdata = 32'd0;
        unique case (op)
            OP_NONE: ;
            OP_CLEAR: clr_next = clr_reg + 1'b1;
            OP_LOAD:
            begin
                bp_next   = (command == CMD_FREE) ? 32'(block_address) : fh_reg;
                need_next = in_need;
                walk_next = '0;
                res_next  = '0;
                st_next   = stat.in_null ? ST_NULL : ST_DONE;
            end
            OP_RD_HDR:    begin acc_re = 1'b1; acc_addr = bp_reg - 32'd4; end
            OP_RD_PB_HDR: begin acc_re = 1'b1; acc_addr = pb_reg - 32'd4; end
            OP_RD_NB_HDR: begin acc_re = 1'b1; acc_addr = nb_reg - 32'd4; end
            OP_FF_RD_NX:  begin acc_re = 1'b1; acc_addr = bp_reg + 32'd4; end
            OP_FF_NX:
            begin
                bp_next   = rdv;
                walk_next = walk_reg + 1'b1;
            end
            OP_FAIL: st_next = ST_NO_SPACE;
            OP_GROW:
            begin
                bytes_next = grow_bytes;
                bp_next    = 32'(brk_reg);
                brk_next   = BRK_W'(32'(brk_reg) + 32'(grow_bytes));
            end
            // new chunk tags and links
            OP_GW1:
            begin
                acc_we = 1'b1; acc_addr = bp_reg - 32'd4; acc_wdata = 32'(bytes_reg);
            end
            OP_GW2:
            begin
                acc_we = 1'b1; acc_addr = bp_reg + 32'(bytes_reg) - 32'd8;
                acc_wdata = 32'(bytes_reg);
            end
            OP_GW3: begin acc_we = 1'b1; acc_addr = bp_reg; end
            OP_GW4: begin acc_we = 1'b1; acc_addr = bp_reg + 32'd4; end
            OP_GW5:
            begin
                acc_we = 1'b1; acc_addr = bp_reg + 32'(bytes_reg) - 32'd4;
                acc_wdata = ALLOC_BIT;
            end
            // neighbour lookup
            OP_MG1: begin acc_re = 1'b1; acc_addr = bp_reg - 32'd8; end
            OP_MG2:
            begin
                pb_next = bp_reg - rsz;
                acc_re = 1'b1; acc_addr = bp_reg - 32'd4;
            end
            OP_MG3:
            begin
                sz_next = rsz;
                nb_next = bp_reg + rsz;
                acc_re = 1'b1; acc_addr = pb_reg - 32'd4;
            end
            OP_MG4:
            begin
                palloc_next = rdv[0];
                acc_re = 1'b1; acc_addr = nb_reg - 32'd4;
            end
            OP_MG5: x_next = palloc_reg ? nb_reg : pb_reg;
            // previous block free
            OP_MA2:
            begin
                tot_next = sz_reg + rsz;
                acc_re = 1'b1; acc_addr = bp_reg - 32'd4;
            end
            OP_MA3:
            begin
                acc_we = 1'b1; acc_addr = bp_reg + rsz - 32'd8; acc_wdata = tot_reg;
            end
            OP_MA4:
            begin
                acc_we = 1'b1; acc_addr = pb_reg - 32'd4; acc_wdata = tot_reg;
                bp_next = pb_reg;
            end
            // next block free
            OP_MB2:
            begin
                tot_next = sz_reg + rsz;
                acc_we = 1'b1; acc_addr = bp_reg - 32'd4; acc_wdata = sz_reg + rsz;
            end
            OP_MB4:
            begin
                acc_we = 1'b1; acc_addr = bp_reg + rsz - 32'd8; acc_wdata = tot_reg;
            end
            // both neighbours free
            OP_MC0: x_next = nb_reg;
            OP_MC2:
            begin
                tot_next = rsz + sz_reg;
                acc_re = 1'b1; acc_addr = nb_reg - 32'd4;
            end
            OP_MC3:
            begin
                tot_next = tot_reg + rsz;
                acc_we = 1'b1; acc_addr = pb_reg - 32'd4; acc_wdata = tot_reg + rsz;
            end
            OP_MC5:
            begin
                acc_we = 1'b1; acc_addr = nb_reg + rsz - 32'd8; acc_wdata = tot_reg;
                bp_next = pb_reg;
            end
            // list insert at head
            OP_MINS: x_next = bp_reg;
            OP_LI1:
            begin
                if (x_reg != 32'd0)
                begin
                    if (fh_reg == 32'd0)
                    begin
                        fh_next = x_reg;
                    end
                    else
                    begin
                        acc_we = 1'b1; acc_addr = x_reg + 32'd4; acc_wdata = fh_reg;
                    end
                end
            end
            OP_LI2:
            begin
                acc_we = 1'b1; acc_addr = fh_reg; acc_wdata = x_reg;
                fh_next = x_reg;
            end
            // list unlink
            OP_LR1: begin acc_re = 1'b1; acc_addr = x_reg - 32'd4; end
            OP_LR2: begin acc_re = 1'b1; acc_addr = x_reg; end
            OP_LR3:
            begin
                prv_next = rdv;
                acc_re = 1'b1; acc_addr = x_reg + 32'd4;
            end
            OP_LR4:
            begin
                nxt_next = rdv;
                acc_we = 1'b1; acc_addr = x_reg;
            end
            OP_LR5: begin acc_we = 1'b1; acc_addr = x_reg + 32'd4; end
            OP_LR6:
            begin
                priority if (prv_reg == 32'd0 && nxt_reg == 32'd0)
                begin
                    fh_next = 32'd0;
                end
                else if (prv_reg == 32'd0)
                begin
                    acc_we = 1'b1; acc_addr = nxt_reg;
                    fh_next = nxt_reg;
                end
                else if (nxt_reg == 32'd0)
                begin
                    acc_we = 1'b1; acc_addr = prv_reg + 32'd4;
                end
                else
                begin
                    acc_we = 1'b1; acc_addr = prv_reg + 32'd4; acc_wdata = nxt_reg;
                end
            end
            OP_LR7:
            begin
                acc_we = 1'b1; acc_addr = nxt_reg; acc_wdata = prv_reg;
            end
            // take block, split remainder
            OP_TK1:
            begin
                fs_next = rsz;
                x_next  = bp_reg;
            end
            OP_TK2:
            begin
                acc_we = 1'b1; acc_addr = bp_reg - 32'd4; acc_wdata = fs_reg | ALLOC_BIT;
            end
            OP_TK3:
            begin
                acc_we = 1'b1; acc_addr = bp_reg + rsz - 32'd8;
                acc_wdata = fs_reg | ALLOC_BIT;
            end
            OP_TK4:
            begin
                res_next = bp_reg[ADDR_W-1:0];
                if (stat.split_ok)
                begin
                    acc_we = 1'b1; acc_addr = bp_reg - 32'd4; acc_wdata = need32 | ALLOC_BIT;
                    nb_next = bp_reg + need32;
                end
            end
            OP_TK5:
            begin
                acc_we = 1'b1; acc_addr = bp_reg + need32 - 32'd8;
                acc_wdata = need32 | ALLOC_BIT;
            end
            OP_TK6: begin acc_we = 1'b1; acc_addr = nb_reg - 32'd4; acc_wdata = rem; end
            OP_TK7:
            begin
                acc_we = 1'b1; acc_addr = nb_reg + rem - 32'd8; acc_wdata = rem;
            end
            OP_TK8:  begin acc_we = 1'b1; acc_addr = nb_reg; end
            OP_TK9:  begin acc_we = 1'b1; acc_addr = nb_reg + 32'd4; end
            OP_TK10: x_next = nb_reg;
            // free: clear allocated bit in both tags
            OP_FR2:
            begin
                sz_next = rsz;
                acc_we = 1'b1; acc_addr = bp_reg - 32'd4; acc_wdata = rsz;
            end
            OP_FR4:
            begin
                acc_we = 1'b1; acc_addr = bp_reg + rsz - 32'd8; acc_wdata = sz_reg;
            end
            OP_FR5: begin acc_we = 1'b1; acc_addr = bp_reg; end
            OP_FR6: begin acc_we = 1'b1; acc_addr = bp_reg + 32'd4; end
            OP_DONE:
            begin
                oaddr_next = res_reg;
                ost_next   = st_reg;
            end
            default: ;
        endcase
    end

    // memory port select
    assign in_range = (acc_addr < 32'(HEAP_BYTES));
    assign mem_wr   = (op == OP_CLEAR) || (acc_we && in_range);
    assign mem_idx  = (op == OP_CLEAR) ? clr_reg : acc_addr[WORD_AW+1:2];

    // heap memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            heap_mem[mem_idx] <= (op == OP_CLEAR) ? init_word(clr_reg) : acc_wdata;
        end
        if (acc_re)
        begin
            rd_q_reg   <= heap_mem[mem_idx];
            rd_oob_reg <= !in_range;
        end
    end

    // heap control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            fh_reg  <= FIRST_BP;
            brk_reg <= BRK_W'(16 + RESET_CHUNK);
            ext_reg <= EXT_W'(RESET_CHUNK);
        end
        else
        begin
            clr_reg <= clr_next;
            fh_reg  <= fh_next;
            brk_reg <= brk_next;
            if (cfg_we)
            begin
                ext_reg <= cfg_wdata;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        bp_reg <= bp_next;   pb_reg <= pb_next;   nb_reg <= nb_next;
        sz_reg <= sz_next;   tot_reg <= tot_next; x_reg <= x_next;
        prv_reg <= prv_next; nxt_reg <= nxt_next; fs_reg <= fs_next;
        need_reg <= need_next; bytes_reg <= bytes_next; walk_reg <= walk_next;
        palloc_reg <= palloc_next; res_reg <= res_next; st_reg <= st_next;
        oaddr_reg <= oaddr_next;   ost_reg <= ost_next;
    end

    assign result_address = oaddr_reg;
    assign status         = ost_reg;

endmodule

// ----- hw/rtl/efla_ctrl.sv -----
// ============================================================================
// efla_ctrl: sequencer of the free list allocator
// One-hot state machine stepping the datapath through the clear pass,
// first-fit walk, heap growth, free, coalescing, list updates and block take.
// ============================================================================
module efla_ctrl
    import efla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t stat,
    output dp_op_t     op,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall
);

    localparam int STATE_W = 61;

    typedef enum logic [STATE_W-1:0] {
        S_CLEAR  = STATE_W'(1) << 0,  S_IDLE   = STATE_W'(1) << 1,
        S_FF_CHK = STATE_W'(1) << 2,  S_FF_SZ  = STATE_W'(1) << 3,
        S_FF_NX  = STATE_W'(1) << 4,  S_GROW   = STATE_W'(1) << 5,
        S_GW1    = STATE_W'(1) << 6,  S_GW2    = STATE_W'(1) << 7,
        S_GW3    = STATE_W'(1) << 8,  S_GW4    = STATE_W'(1) << 9,
        S_GW5    = STATE_W'(1) << 10, S_GW_END = STATE_W'(1) << 11,
        S_MG1    = STATE_W'(1) << 12, S_MG2    = STATE_W'(1) << 13,
        S_MG3    = STATE_W'(1) << 14, S_MG4    = STATE_W'(1) << 15,
        S_MG5    = STATE_W'(1) << 16, S_MA1    = STATE_W'(1) << 17,
        S_MA2    = STATE_W'(1) << 18, S_MA3    = STATE_W'(1) << 19,
        S_MA4    = STATE_W'(1) << 20, S_MB1    = STATE_W'(1) << 21,
        S_MB2    = STATE_W'(1) << 22, S_MB3    = STATE_W'(1) << 23,
        S_MB4    = STATE_W'(1) << 24, S_MC0    = STATE_W'(1) << 25,
        S_MC1    = STATE_W'(1) << 26, S_MC2    = STATE_W'(1) << 27,
        S_MC3    = STATE_W'(1) << 28, S_MC4    = STATE_W'(1) << 29,
        S_MC5    = STATE_W'(1) << 30, S_MINS   = STATE_W'(1) << 31,
        S_MG_END = STATE_W'(1) << 32, S_LI1    = STATE_W'(1) << 33,
        S_LI2    = STATE_W'(1) << 34, S_LR1    = STATE_W'(1) << 35,
        S_LR2    = STATE_W'(1) << 36, S_LR3    = STATE_W'(1) << 37,
        S_LR4    = STATE_W'(1) << 38, S_LR5    = STATE_W'(1) << 39,
        S_LR6    = STATE_W'(1) << 40, S_LR7    = STATE_W'(1) << 41,
        S_TK_RD  = STATE_W'(1) << 42, S_TK1    = STATE_W'(1) << 43,
        S_TK2    = STATE_W'(1) << 44, S_TK3A   = STATE_W'(1) << 45,
        S_TK3    = STATE_W'(1) << 46, S_TK4    = STATE_W'(1) << 47,
        S_TK5    = STATE_W'(1) << 48, S_TK6    = STATE_W'(1) << 49,
        S_TK7    = STATE_W'(1) << 50, S_TK8    = STATE_W'(1) << 51,
        S_TK9    = STATE_W'(1) << 52, S_TK10   = STATE_W'(1) << 53,
        S_FR1    = STATE_W'(1) << 54, S_FR2    = STATE_W'(1) << 55,
        S_FR3    = STATE_W'(1) << 56, S_FR4    = STATE_W'(1) << 57,
        S_FR5    = STATE_W'(1) << 58, S_FR6    = STATE_W'(1) << 59,
        S_DONE   = STATE_W'(1) << 60
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;       // return point of list routines
    logic   mg_grow_reg, mg_grow_next; // merge entered from heap growth
    logic   ov_reg, ov_next;

    // next state and datapath operation
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        mg_grow_next = mg_grow_reg;
        ov_next      = ov_reg;
        op           = OP_NONE;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                op = OP_CLEAR;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = OP_LOAD;
                    priority if (stat.in_null) state_next = S_DONE;
                    else if (stat.in_free)     state_next = S_FR1;
                    else                       state_next = S_FF_CHK;
                end
            end
            // first-fit walk
            S_FF_CHK:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_GROW;
                end
                else
                begin
                    op = OP_RD_HDR; state_next = S_FF_SZ;
                end
            end
            S_FF_SZ:
            begin
                if (stat.fit)
                begin
                    state_next = S_TK_RD;
                end
                else
                begin
                    op = OP_FF_RD_NX; state_next = S_FF_NX;
                end
            end
            S_FF_NX: begin op = OP_FF_NX; state_next = S_FF_CHK; end
            // heap growth
            S_GROW:
            begin
                if (stat.grow_fail)
                begin
                    op = OP_FAIL; state_next = S_DONE;
                end
                else
                begin
                    op = OP_GROW; state_next = S_GW1;
                end
            end
            S_GW1: begin op = OP_GW1; state_next = S_GW2; end
            S_GW2: begin op = OP_GW2; state_next = S_GW3; end
            S_GW3: begin op = OP_GW3; state_next = S_GW4; end
            S_GW4: begin op = OP_GW4; state_next = S_GW5; end
            S_GW5:
            begin
                op = OP_GW5; mg_grow_next = 1'b1; state_next = S_MG1;
            end
            S_GW_END:
            begin
                if (stat.bp_zero)
                begin
                    op = OP_FAIL; state_next = S_DONE;
                end
                else
                begin
                    state_next = S_TK_RD;
                end
            end
            // coalescing
            S_MG1: begin op = OP_MG1; state_next = S_MG2; end
            S_MG2: begin op = OP_MG2; state_next = S_MG3; end
            S_MG3: begin op = OP_MG3; state_next = S_MG4; end
            S_MG4: begin op = OP_MG4; state_next = S_MG5; end
            S_MG5:
            begin
                op = OP_MG5;
                priority if (stat.p_alloc && stat.rd_alloc)
                begin
                    state_next = S_MINS;
                end
                else if (stat.p_alloc)
                begin
                    ret_next = S_MB1; state_next = S_LR1;
                end
                else if (stat.rd_alloc)
                begin
                    ret_next = S_MA1; state_next = S_LR1;
                end
                else
                begin
                    ret_next = S_MC0; state_next = S_LR1;
                end
            end
            S_MA1: begin op = OP_RD_PB_HDR; state_next = S_MA2; end
            S_MA2: begin op = OP_MA2; state_next = S_MA3; end
            S_MA3: begin op = OP_MA3; state_next = S_MA4; end
            S_MA4: begin op = OP_MA4; state_next = S_MINS; end
            S_MB1: begin op = OP_RD_NB_HDR; state_next = S_MB2; end
            S_MB2: begin op = OP_MB2; state_next = S_MB3; end
            S_MB3: begin op = OP_RD_HDR; state_next = S_MB4; end
            S_MB4: begin op = OP_MB4; state_next = S_MINS; end
            S_MC0:
            begin
                op = OP_MC0; ret_next = S_MC1; state_next = S_LR1;
            end
            S_MC1: begin op = OP_RD_PB_HDR; state_next = S_MC2; end
            S_MC2: begin op = OP_MC2; state_next = S_MC3; end
            S_MC3: begin op = OP_MC3; state_next = S_MC4; end
            S_MC4: begin op = OP_RD_NB_HDR; state_next = S_MC5; end
            S_MC5: begin op = OP_MC5; state_next = S_MINS; end
            S_MINS:
            begin
                op = OP_MINS; ret_next = S_MG_END; state_next = S_LI1;
            end
            S_MG_END: state_next = mg_grow_reg ? S_GW_END : S_DONE;
            // list insert
            S_LI1:
            begin
                op = OP_LI1;
                state_next = (stat.x_zero || stat.fh_zero) ? ret_reg : S_LI2;
            end
            S_LI2: begin op = OP_LI2; state_next = ret_reg; end
            // list unlink
            S_LR1:
            begin
                if (stat.x_zero)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    op = OP_LR1; state_next = S_LR2;
                end
            end
            S_LR2:
            begin
                if (stat.rd_alloc)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    op = OP_LR2; state_next = S_LR3;
                end
            end
            S_LR3: begin op = OP_LR3; state_next = S_LR4; end
            S_LR4: begin op = OP_LR4; state_next = S_LR5; end
            S_LR5: begin op = OP_LR5; state_next = S_LR6; end
            S_LR6:
            begin
                op = OP_LR6;
                state_next = (!stat.prv_zero && !stat.nxt_zero) ? S_LR7 : ret_reg;
            end
            S_LR7: begin op = OP_LR7; state_next = ret_reg; end
            // take
            S_TK_RD: begin op = OP_RD_HDR; state_next = S_TK1; end
            S_TK1:
            begin
                op = OP_TK1; ret_next = S_TK2; state_next = S_LR1;
            end
            S_TK2:  begin op = OP_TK2; state_next = S_TK3A; end
            S_TK3A: begin op = OP_RD_HDR; state_next = S_TK3; end
            S_TK3:  begin op = OP_TK3; state_next = S_TK4; end
            S_TK4:
            begin
                op = OP_TK4;
                state_next = stat.split_ok ? S_TK5 : S_DONE;
            end
            S_TK5: begin op = OP_TK5; state_next = S_TK6; end
            S_TK6: begin op = OP_TK6; state_next = S_TK7; end
            S_TK7: begin op = OP_TK7; state_next = S_TK8; end
            S_TK8: begin op = OP_TK8; state_next = S_TK9; end
            S_TK9: begin op = OP_TK9; state_next = S_TK10; end
            S_TK10:
            begin
                op = OP_TK10; ret_next = S_DONE; state_next = S_LI1;
            end
            // free
            S_FR1: begin op = OP_RD_HDR; state_next = S_FR2; end
            S_FR2: begin op = OP_FR2; state_next = S_FR3; end
            S_FR3: begin op = OP_RD_HDR; state_next = S_FR4; end
            S_FR4: begin op = OP_FR4; state_next = S_FR5; end
            S_FR5: begin op = OP_FR5; state_next = S_FR6; end
            S_FR6:
            begin
                op = OP_FR6; mg_grow_next = 1'b0; state_next = S_MG1;
            end
            // hand over to output register
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    op = OP_DONE; ov_next = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            ret_reg     <= S_IDLE;
            mg_grow_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            mg_grow_reg <= mg_grow_next;
            ov_reg      <= ov_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

endmodule

// ----- hw/rtl/explicit_free_list_allocator_unit.sv -----
// ============================================================================
// explicit_free_list_allocator_unit: boundary-tag heap allocator
// First-fit allocate and coalescing free over a word heap memory with an
// explicit LIFO doubly linked free list.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   cfg     | in        | cfg_we                 | cfg_wdata (extend chunk bytes)
//   in      | in        | in_valid / in_stall    | command, request_size,
//           |           |                        | block_address
//   out     | out       | out_valid / out_stall  | result_address, status
//
// Each step makes at most one access to the single-port heap memory.
// After reset a clearing pass writes the power-up layout to every heap word;
// in_stall stays high meanwhile. One request is in work at a time; a finished
// result waits in the output register and the next request is taken meanwhile.
// ============================================================================
module explicit_free_list_allocator_unit
    import efla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [EXT_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    input  logic [REQ_W-1:0]  request_size,
    input  logic [ADDR_W-1:0] block_address,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] result_address,
    output logic [1:0]        status
);

    dp_op_t     op;
    dp_status_t stat;

    // sequencer
    efla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .op        (op),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    // heap memory and registers
    efla_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .command        (command),
        .request_size   (request_size),
        .block_address  (block_address),
        .result_address (result_address),
        .status         (status)
    );

`ifndef NO_ASSERTIONS
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while another is in work");

    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_address != '0) |-> (status == ST_DONE))
        else $error("block address returned with failure status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_DONE || status == ST_NO_SPACE || status == ST_NULL))
        else $error("undefined status code");
`endif

endmodule
